@@ rtl/b64enc_pkg.sv @@
`timescale 1ns / 1ps

package b64enc_pkg;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [6:0] PAD_CHAR = 7'd61;

   // One group of up to three bytes on its way to the character serialiser.
   // byte_count holds the number of real bytes less one.
   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
      logic [1:0] byte_count;
      logic       end_of_message;
   } group_type;

   function automatic logic [6:0] b64_char(input logic [5:0] idx);
      logic [6:0] code;
      if (idx < 6'd26) begin
         code = 7'd65 + {1'b0, idx};
      end else if (idx < 6'd52) begin
         code = 7'd97 + {1'b0, idx} - 7'd26;
      end else if (idx < 6'd62) begin
         code = 7'd48 + {1'b0, idx} - 7'd52;
      end else if (idx == 6'd62) begin
         code = 7'd43;
      end else begin
         code = 7'd47;
      end
      return code;
   endfunction

   function automatic logic [5:0] b64_index(input group_type grp, input logic [1:0] pos);
      logic [5:0] idx;
      case (pos)
         2'd0: idx = grp.byte0[7:2];
         2'd1: idx = {grp.byte0[1:0], grp.byte1[7:4]};
         2'd2: idx = {grp.byte1[3:0], grp.byte2[7:6]};
         default: idx = grp.byte2[5:0];
      endcase
      return idx;
   endfunction

endpackage

@@ rtl/b64enc_front.sv @@
`timescale 1ns / 1ps

module b64enc_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_push,
   input  logic [7:0]           req_data_byte,
   input  logic                 req_end_of_message,
   input  logic                 q_full,
   output logic                 q_push,
   output b64enc_pkg::group_type q_group
);

   logic [7:0] pend0_ff, pend0_in;
   logic [7:0] pend1_ff, pend1_in;
   logic [1:0] count_ff, count_in;
   logic [1:0] cnt;
   logic       accept;

   always_comb begin
      // A count of three cannot arise; it is handled as a full pair.
      cnt = (count_ff == 2'd3) ? 2'd2 : count_ff;
      accept = req_push && !q_full;
      pend0_in = pend0_ff;
      pend1_in = pend1_ff;
      count_in = count_ff;
      q_push = 1'b0;

      q_group.byte0 = (cnt == 2'd0) ? req_data_byte : pend0_ff;
      q_group.byte1 = (cnt == 2'd0) ? 8'd0 : ((cnt == 2'd1) ? req_data_byte : pend1_ff);
      q_group.byte2 = (cnt == 2'd2) ? req_data_byte : 8'd0;
      q_group.byte_count = cnt;
      q_group.end_of_message = req_end_of_message;

      if (accept) begin
         if (cnt != 2'd2 && !req_end_of_message) begin
            if (cnt == 2'd0) begin
               pend0_in = req_data_byte;
            end else begin
               pend1_in = req_data_byte;
            end
            count_in = cnt + 2'd1;
         end else begin
            q_push = 1'b1;
            count_in = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
      pend0_ff <= pend0_in;
      pend1_ff <= pend1_in;
   end

endmodule

@@ rtl/b64enc_queue.sv @@
`timescale 1ns / 1ps

module b64enc_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  b64enc_pkg::group_type push_group,
   input  logic                  pop,
   output b64enc_pkg::group_type head_group,
   output logic                  full,
   output logic                  empty
);

   b64enc_pkg::group_type entry_ff [b64enc_pkg::QUEUE_DEPTH];
   logic [b64enc_pkg::QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [b64enc_pkg::QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [b64enc_pkg::QUEUE_CNT_W-1:0] count_ff, count_in;

   localparam logic [b64enc_pkg::QUEUE_CNT_W-1:0] DEPTH_CNT =
      b64enc_pkg::QUEUE_CNT_W'(b64enc_pkg::QUEUE_DEPTH);
   localparam logic [b64enc_pkg::QUEUE_PTR_W-1:0] LAST_PTR =
      b64enc_pkg::QUEUE_PTR_W'(b64enc_pkg::QUEUE_DEPTH - 1);

   always_comb begin
      full = (count_ff == DEPTH_CNT);
      empty = (count_ff == '0);
      head_group = entry_ff[rd_ptr_ff];
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_group;
      end
   end

endmodule

@@ rtl/b64enc_back.sv @@
`timescale 1ns / 1ps

module b64enc_back (
   input  logic                  clock,
   input  logic                  reset,
   input  b64enc_pkg::group_type head_group,
   input  logic                  q_empty,
   output logic                  q_pop,
   input  logic                  rsp_pop,
   output logic                  rsp_empty,
   output logic [6:0]            rsp_out_char,
   output logic                  rsp_last_char
);

   logic [1:0] pos_ff, pos_in;
   logic       valid_ff, valid_in;
   logic [6:0] char_ff, char_in;
   logic       last_ff, last_in;
   logic       load;
   logic       is_pad;

   always_comb begin
      load = (!valid_ff || rsp_pop) && !q_empty;
      // Characters beyond the real bytes plus one become padding.
      is_pad = (pos_ff == 2'd3 && head_group.byte_count != 2'd2) ||
               (pos_ff == 2'd2 && head_group.byte_count == 2'd0);
      pos_in = pos_ff;
      valid_in = valid_ff;
      char_in = char_ff;
      last_in = last_ff;
      q_pop = 1'b0;
      if (load) begin
         char_in = is_pad ? b64enc_pkg::PAD_CHAR :
                   b64enc_pkg::b64_char(b64enc_pkg::b64_index(head_group, pos_ff));
         last_in = head_group.end_of_message && (pos_ff == 2'd3);
         valid_in = 1'b1;
         pos_in = pos_ff + 2'd1;
         q_pop = (pos_ff == 2'd3);
      end else if (rsp_pop) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= 2'd0;
         valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         valid_ff <= valid_in;
      end
      char_ff <= char_in;
      last_ff <= last_in;
   end

   assign rsp_empty = !valid_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last_char = last_ff;

endmodule

@@ rtl/base64_stream_encoder_unit.sv @@
`timescale 1ns / 1ps

// Streaming base64 encoder with '=' padding. A byte is taken in every cycle
// that full is low; complete groups of three bytes, or a short group closed
// by the end-of-message flag, pass through a two-group queue to a serialiser
// that sends one character per cycle while rsp_pop is high, four per group,
// the last character of a message flagged. The single character port sets the
// sustained rate, while a burst of up to two groups is absorbed by the queue.
// The closing byte of a group is written into the queue; its first character
// is then loaded into the output character register.
module base64_stream_encoder_unit (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_push,
   input  logic [7:0] req_data_byte,
   input  logic       req_end_of_message,
   output logic       req_full,
   input  logic       rsp_pop,
   output logic       rsp_empty,
   output logic [6:0] rsp_out_char,
   output logic       rsp_last_char
);

   b64enc_pkg::group_type push_group;
   b64enc_pkg::group_type head_group;
   logic q_push;
   logic q_pop;
   logic q_full;
   logic q_empty;

   b64enc_front u_front (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .q_full             (q_full),
      .q_push             (q_push),
      .q_group            (push_group)
   );

   b64enc_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_group (push_group),
      .pop        (q_pop),
      .head_group (head_group),
      .full       (q_full),
      .empty      (q_empty)
   );

   b64enc_back u_back (
      .clock         (clock),
      .reset         (reset),
      .head_group    (head_group),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_pop       (rsp_pop),
      .rsp_empty     (rsp_empty),
      .rsp_out_char  (rsp_out_char),
      .rsp_last_char (rsp_last_char)
   );

   assign req_full = q_full;

`ifndef SYNTHESIS
   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("group queue read while empty");

   a_no_push_when_full: assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("group queue written while full");

   a_empty_after_reset: assert property (@(posedge clock)
      reset |=> rsp_empty)
      else $error("result shown straight after reset");

   a_group_needs_space: assert property (@(posedge clock) disable iff (reset)
      q_push |-> (req_push && !req_full))
      else $error("group queued without an accepted transaction");
`endif

endmodule

@@ tb/sv/base64_stream_encoder_unit_tb.sv @@
`timescale 1ns / 1ps

module base64_stream_encoder_unit_tb;

   localparam int unsigned STALL_LIMIT = 2000;
   localparam int unsigned IDLE_PCT    = 23;

   typedef struct packed {
      logic [6:0] code;
      logic       last;
   } encoded_char_type;

   // Tracks the bytes waiting in the current group and the characters still owed.
   class encoded_char_tracker;
      string            alphabet;
      logic [7:0]       held[2];
      int unsigned      held_count;
      encoded_char_type expected_chars[$];
      int unsigned      mismatch_count;

      function new();
         alphabet       = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
         held_count     = 0;
         mismatch_count = 0;
      endfunction

      function int unsigned outstanding();
         return expected_chars.size();
      endfunction

      function void note_byte(input logic [7:0] data, input logic eom);
         logic [7:0]       b0;
         logic [7:0]       b1;
         logic [7:0]       b2;
         logic [5:0]       idx[4];
         byte unsigned     ch;
         encoded_char_type c;
         if (held_count < 2 && !eom) begin
            held[held_count] = data;
            held_count++;
            return;
         end
         // Bytes missing from a short group are taken as zero.
         b0 = (held_count == 0) ? data : held[0];
         b1 = (held_count == 0) ? 8'h00 : ((held_count == 1) ? data : held[1]);
         b2 = (held_count == 2) ? data : 8'h00;
         idx[0] = b0[7:2];
         idx[1] = {b0[1:0], b1[7:4]};
         idx[2] = {b1[3:0], b2[7:6]};
         idx[3] = b2[5:0];
         // A group of n real bytes gives n + 1 alphabet characters.
         for (int k = 0; k < 4; k++) begin
            ch = alphabet.getc(idx[k]);
            c.code = (k < held_count + 2) ? ch[6:0] : b64enc_pkg::PAD_CHAR;
            c.last = eom && (k == 3);
            expected_chars.insert(expected_chars.size(), c);
         end
         held_count = 0;
      endfunction

      task report(input string what);
         $display("mismatch at %0t: %s", $realtime, what);
         mismatch_count++;
      endtask

      task check_char(input logic [6:0] code, input logic last);
         encoded_char_type want;
         if (expected_chars.size() == 0) begin
            report($sformatf("unexpected character %0d last %0b", code, last));
            return;
         end
         want = expected_chars[0];
         expected_chars.delete(0);
         if (code !== want.code) begin
            report($sformatf("character %0d, expected %0d", code, want.code));
         end
         if (last !== want.last) begin
            report($sformatf("last flag %0b on character %0d, expected %0b",
                             last, code, want.last));
         end
      endtask
   endclass

   logic       clock = 1'b0;
   logic       reset;
   logic       req_push;
   logic [7:0] req_data_byte;
   logic       req_end_of_message;
   logic       req_full;
   logic       rsp_pop;
   logic       rsp_empty;
   logic [6:0] rsp_out_char;
   logic       rsp_last_char;

   encoded_char_tracker tracker;
   logic                byte_taken;
   logic                char_taken;
   int unsigned         send_idle;
   int unsigned         recv_idle;
   int unsigned         stall_cycles;

   base64_stream_encoder_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_push           (req_push),
      .req_data_byte      (req_data_byte),
      .req_end_of_message (req_end_of_message),
      .req_full           (req_full),
      .rsp_pop            (rsp_pop),
      .rsp_empty          (rsp_empty),
      .rsp_out_char       (rsp_out_char),
      .rsp_last_char      (rsp_last_char)
   );

   always #2 clock = ~clock;

   always @(posedge clock) begin
      rsp_pop <= !reset && ($urandom_range(99) >= recv_idle);
   end

   // Inputs only change just after a rising edge, so the values seen at the
   // falling edge are the ones the next rising edge will act on.
   always @(negedge clock) begin
      byte_taken = !reset && req_push && !req_full;
      char_taken = !reset && rsp_pop && !rsp_empty;
      if (byte_taken) begin
         tracker.note_byte(req_data_byte, req_end_of_message);
      end
      if (char_taken) begin
         tracker.check_char(rsp_out_char, rsp_last_char);
      end
      if (reset || byte_taken || char_taken) begin
         stall_cycles = 0;
      end else begin
         stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("base64_stream_encoder_unit regression: fail");
            $finish;
         end
      end
   end

   task send_byte(input logic [7:0] data, input logic eom);
      while ($urandom_range(99) < send_idle) begin
         req_push <= 1'b0;
         @(posedge clock);
      end
      req_push           <= 1'b1;
      req_data_byte      <= data;
      req_end_of_message <= eom;
      do @(posedge clock); while (!byte_taken);
   endtask

   task wait_drained();
      while (tracker.outstanding() != 0) @(posedge clock);
   endtask

   function automatic logic [7:0] pick_byte();
      int unsigned roll;
      roll = $urandom_range(7);
      if (roll == 0) begin
         return 8'h00;
      end else if (roll == 1) begin
         return 8'hff;
      end
      return 8'($urandom_range(255));
   endfunction

   initial begin
      int unsigned random_items;
      int unsigned msg_len;
      tracker            = new();
      byte_taken         = 1'b0;
      char_taken         = 1'b0;
      stall_cycles       = 0;
      send_idle          = IDLE_PCT;
      recv_idle          = IDLE_PCT;
      reset              <= 1'b1;
      req_push           <= 1'b0;
      req_data_byte      <= 8'h00;
      req_end_of_message <= 1'b0;
      rsp_pop            <= 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Short groups with one and two bytes, at both extremes of the byte.
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'h00, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      // Full groups closed by the final byte, giving '/' and '+' throughout.
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'hfb, 1'b0);
      send_byte(8'hef, 1'b0);
      send_byte(8'hbe, 1'b1);
      // A full group followed by a short one in the same message.
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h55, 1'b1);
      send_byte(8'haa, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hcc, 1'b0);
      send_byte(8'h33, 1'b0);
      send_byte(8'hc3, 1'b1);
      req_push <= 1'b0;

      // Hold the sender back until the serialiser has emptied completely.
      wait_drained();

      random_items = 0;
      while (random_items < 100) begin
         // The first stretch runs with both sides at full rate.
         send_idle = (random_items < 40) ? 0 : IDLE_PCT;
         recv_idle = send_idle;
         msg_len   = ($urandom_range(9) == 0) ? $urandom_range(24, 10)
                                              : $urandom_range(9, 1);
         for (int n = 1; n <= msg_len; n++) begin
            send_byte(pick_byte(), n == msg_len);
            random_items++;
         end
      end
      req_push <= 1'b0;

      wait_drained();
      repeat (8) @(posedge clock);
      if (tracker.mismatch_count == 0 && tracker.outstanding() == 0) begin
         $display("base64_stream_encoder_unit regression: pass");
      end else begin
         $display("base64_stream_encoder_unit regression: fail");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/b64enc_pkg.sv
rtl/b64enc_front.sv
rtl/b64enc_queue.sv
rtl/b64enc_back.sv
rtl/base64_stream_encoder_unit.sv
tb/sv/base64_stream_encoder_unit_tb.sv
